// ----- sv/cc3d_pkg.sv -----
// shared types and constants of the three-point circumcentre core
package cc3d_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int LIMB_W      = 32;
   localparam int MUL_LAT     = 4;

   localparam int UW   = COORD_WIDTH + 1;
   localparam int NW   = 2 * UW + 1;
   localparam int NNW  = 2 * NW + 2;
   localparam int DENW = NNW + 1;
   localparam int WW   = NW + UW + 1;
   localparam int TW   = ((WW + NW > COORD_WIDTH + DENW) ? WW + NW : COORD_WIDTH + DENW) + 2;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic [COORD_WIDTH-1:0]        NEG_LIMIT = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_COLLINEAR = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] first_x;
      logic signed [COORD_WIDTH-1:0] first_y;
      logic signed [COORD_WIDTH-1:0] first_z;
      logic signed [COORD_WIDTH-1:0] second_x;
      logic signed [COORD_WIDTH-1:0] second_y;
      logic signed [COORD_WIDTH-1:0] second_z;
      logic signed [COORD_WIDTH-1:0] third_x;
      logic signed [COORD_WIDTH-1:0] third_y;
      logic signed [COORD_WIDTH-1:0] third_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] center_x_out;
      logic signed [COORD_WIDTH-1:0] center_y_out;
      logic signed [COORD_WIDTH-1:0] center_z_out;
      status_type                    status;
   } rsp_type;

endpackage

// ----- sv/cc3d_mul.sv -----
// pipelined signed multiplier built from 32x32 partial products
module cc3d_mul
   import cc3d_pkg::*;
#(
   parameter int AW = 32,
   parameter int BW = 32
)(
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [AW-1:0]    a,
   input  logic signed [BW-1:0]    b,
   output logic signed [AW+BW-1:0] p
);

   localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
   localparam int NB = (BW + LIMB_W - 1) / LIMB_W;
   localparam int PW = AW + BW;

   logic [AW-1:0]          a_abs;
   logic [BW-1:0]          b_abs;
   logic [NA*LIMB_W-1:0]   amag_ff, amag_in;
   logic [NB*LIMB_W-1:0]   bmag_ff, bmag_in;
   logic                   neg1_ff, neg2_ff, neg3_ff;
   logic [2*LIMB_W-1:0]    pp_ff [NA][NB];
   logic [2*LIMB_W-1:0]    pp_in [NA][NB];
   logic [PW-1:0]          sum_ff, sum_in;
   logic signed [PW-1:0]   p_ff, p_in;

   always_comb begin
      a_abs   = a[AW-1] ? AW'(-a) : AW'(a);
      b_abs   = b[BW-1] ? BW'(-b) : BW'(b);
      amag_in = (NA*LIMB_W)'(a_abs);
      bmag_in = (NB*LIMB_W)'(b_abs);
   end

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = amag_ff[i*LIMB_W +: LIMB_W] * bmag_ff[j*LIMB_W +: LIMB_W];
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (PW'(pp_ff[i][j]) << (LIMB_W * (i + j)));
         end
      end
   end

   always_comb p_in = neg3_ff ? PW'(-sum_ff) : PW'(sum_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         amag_ff <= amag_in;
         bmag_ff <= bmag_in;
         neg1_ff <= a[AW-1] ^ b[BW-1];
         pp_ff   <= pp_in;
         neg2_ff <= neg1_ff;
         sum_ff  <= sum_in;
         neg3_ff <= neg2_ff;
         p_ff    <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// ----- sv/circumcenter_three_points_3d_core.sv -----
// Circumcentre of three 3D points in signed Q8.16: one point triple enters per clock and its
// result goes through the three pipelined multiplier groups and the 25-stage restoring divider
// (three lanes; the first stage checks for overflow, each later stage gives one quotient bit).
// The pipeline advances as one, holding only while a finished word waits on rsp_stall. Collinear
// points give zero coordinates with status 1; an out-of-range coordinate saturates with status 2.
module circumcenter_three_points_3d_core
   import cc3d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   localparam int K     = COORD_WIDTH + 1;
   localparam int DEPTH = 4 + 3 * (MUL_LAT + 1) + K;

   logic             adv;
   logic [DEPTH-1:0] vld_ff, vld_in;

   // input word
   req_type in_ff;

   // point a and edge vectors
   logic signed [COORD_WIDTH-1:0] a2_ff [3];
   logic signed [COORD_WIDTH-1:0] a2_in [3];
   logic signed [UW-1:0]          u2_ff [3];
   logic signed [UW-1:0]          u2_in [3];
   logic signed [UW-1:0]          v2_ff [3];
   logic signed [UW-1:0]          v2_in [3];

   logic signed [2*UW-1:0] m1_pa [3];
   logic signed [2*UW-1:0] m1_pb [3];
   logic signed [2*UW-1:0] m1_uu [3];
   logic signed [2*UW-1:0] m1_vv [3];

   logic signed [COORD_WIDTH-1:0] ad1_ff [MUL_LAT][3];
   logic signed [UW-1:0]          ud1_ff [MUL_LAT][3];
   logic signed [UW-1:0]          vd1_ff [MUL_LAT][3];

   // normal and squared lengths
   logic signed [NW-1:0]          n7_ff [3];
   logic signed [NW-1:0]          n7_in [3];
   logic signed [NW-1:0]          uu7_ff, uu7_in, vv7_ff, vv7_in;
   logic signed [COORD_WIDTH-1:0] a7_ff [3];
   logic signed [UW-1:0]          u7_ff [3];
   logic signed [UW-1:0]          v7_ff [3];

   logic signed [2*NW-1:0]    m2_sq [3];
   logic signed [NW+UW-1:0]   m2_wa [3];
   logic signed [NW+UW-1:0]   m2_wb [3];

   logic signed [COORD_WIDTH-1:0] ad2_ff [MUL_LAT][3];
   logic signed [NW-1:0]          nd2_ff [MUL_LAT][3];

   // determinant and bisector terms
   logic signed [NNW-1:0]         nn12;
   logic signed [DENW-1:0]        den12_ff, den12_in;
   logic                          zero12_ff, zero12_in;
   logic signed [WW-1:0]          w12_ff [3];
   logic signed [WW-1:0]          w12_in [3];
   logic signed [NW-1:0]          n12_ff [3];
   logic signed [COORD_WIDTH-1:0] a12_ff [3];

   logic signed [WW+NW-1:0]          m3_pa [3];
   logic signed [WW+NW-1:0]          m3_pb [3];
   logic signed [COORD_WIDTH+DENW-1:0] m3_ad [3];

   logic signed [DENW-1:0] dd3_ff [MUL_LAT];
   logic                   zd3_ff [MUL_LAT];

   // numerators
   logic signed [TW-1:0]   t17_ff [3];
   logic signed [TW-1:0]   t17_in [3];
   logic signed [DENW-1:0] den17_ff;
   logic                   zero17_ff;

   logic [TW-1:0]          mag18_ff [3];
   logic [TW-1:0]          mag18_in [3];
   logic                   neg18_ff [3];
   logic [DENW-1:0]        den18_ff;
   logic                   zero18_ff;

   // divider stages
   logic [TW-1:0]          rem_ff  [K][3];
   logic [TW-1:0]          rem_in  [K][3];
   logic [TW-1:0]          rem_src [K][3];
   logic [COORD_WIDTH-1:0] q_ff    [K][3];
   logic [COORD_WIDTH-1:0] q_in    [K][3];
   logic [COORD_WIDTH-1:0] q_src   [K][3];
   logic                   ovf_ff  [K][3];
   logic                   ovf_in  [K][3];
   logic                   ovf_src [K][3];
   logic                   neg_ff  [K][3];
   logic                   neg_src [K][3];
   logic [DENW-1:0]        dden_ff [K];
   logic [DENW-1:0]        dden_src [K];
   logic                   dzero_ff [K];
   logic                   dzero_src [K];
   logic [TW-1:0]          dsh [K];
   logic                   ge  [K][3];

   logic signed [COORD_WIDTH-1:0] res [3];
   logic                          sat_any;
   rsp_type                       rsp_ff, rsp_in;

   // pipeline control
   assign rsp_valid = vld_ff[DEPTH-1];
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   always_comb vld_in = {vld_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // edge vectors
   always_comb begin
      a2_in[0] = in_ff.first_x;
      a2_in[1] = in_ff.first_y;
      a2_in[2] = in_ff.first_z;
      u2_in[0] = UW'(in_ff.second_x) - UW'(in_ff.first_x);
      u2_in[1] = UW'(in_ff.second_y) - UW'(in_ff.first_y);
      u2_in[2] = UW'(in_ff.second_z) - UW'(in_ff.first_z);
      v2_in[0] = UW'(in_ff.third_x) - UW'(in_ff.first_x);
      v2_in[1] = UW'(in_ff.third_y) - UW'(in_ff.first_y);
      v2_in[2] = UW'(in_ff.third_z) - UW'(in_ff.first_z);
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         n7_in[l] = NW'(m1_pa[l]) - NW'(m1_pb[l]);
      end
      uu7_in = NW'(m1_uu[0]) + NW'(m1_uu[1]) + NW'(m1_uu[2]);
      vv7_in = NW'(m1_vv[0]) + NW'(m1_vv[1]) + NW'(m1_vv[2]);
   end

   always_comb begin
      nn12      = NNW'(m2_sq[0]) + NNW'(m2_sq[1]) + NNW'(m2_sq[2]);
      den12_in  = DENW'(nn12) + DENW'(nn12);
      zero12_in = (nn12 == '0);
      for (int l = 0; l < 3; l++) begin
         w12_in[l] = WW'(m2_wa[l]) - WW'(m2_wb[l]);
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         t17_in[l]   = TW'(m3_ad[l]) + TW'(m3_pa[l]) - TW'(m3_pb[l]);
         mag18_in[l] = t17_ff[l][TW-1] ? TW'(-t17_ff[l]) : TW'(t17_ff[l]);
      end
   end

   genvar k;
   generate
      for (k = 0; k < 3; k++) begin : g_lane
         localparam int I1 = (k + 1) % 3;
         localparam int I2 = (k + 2) % 3;

         cc3d_mul #(.AW(UW), .BW(UW)) u_npa (
            .clock(clock), .en(adv), .a(u2_ff[I1]), .b(v2_ff[I2]), .p(m1_pa[k]));
         cc3d_mul #(.AW(UW), .BW(UW)) u_npb (
            .clock(clock), .en(adv), .a(u2_ff[I2]), .b(v2_ff[I1]), .p(m1_pb[k]));
         cc3d_mul #(.AW(UW), .BW(UW)) u_uu (
            .clock(clock), .en(adv), .a(u2_ff[k]), .b(u2_ff[k]), .p(m1_uu[k]));
         cc3d_mul #(.AW(UW), .BW(UW)) u_vv (
            .clock(clock), .en(adv), .a(v2_ff[k]), .b(v2_ff[k]), .p(m1_vv[k]));

         cc3d_mul #(.AW(NW), .BW(NW)) u_sq (
            .clock(clock), .en(adv), .a(n7_ff[k]), .b(n7_ff[k]), .p(m2_sq[k]));
         cc3d_mul #(.AW(NW), .BW(UW)) u_wa (
            .clock(clock), .en(adv), .a(uu7_ff), .b(v7_ff[k]), .p(m2_wa[k]));
         cc3d_mul #(.AW(NW), .BW(UW)) u_wb (
            .clock(clock), .en(adv), .a(vv7_ff), .b(u7_ff[k]), .p(m2_wb[k]));

         cc3d_mul #(.AW(WW), .BW(NW)) u_tpa (
            .clock(clock), .en(adv), .a(w12_ff[I1]), .b(n12_ff[I2]), .p(m3_pa[k]));
         cc3d_mul #(.AW(WW), .BW(NW)) u_tpb (
            .clock(clock), .en(adv), .a(w12_ff[I2]), .b(n12_ff[I1]), .p(m3_pb[k]));
         cc3d_mul #(.AW(COORD_WIDTH), .BW(DENW)) u_tad (
            .clock(clock), .en(adv), .a(a12_ff[k]), .b(den12_ff), .p(m3_ad[k]));
      end
   endgenerate

   // restoring divider: the first stage checks for overflow, each later stage gives one quotient bit
   always_comb begin
      rem_src[0]   = mag18_ff;
      q_src[0]     = '{default: '0};
      ovf_src[0]   = '{default: 1'b0};
      neg_src[0]   = neg18_ff;
      dden_src[0]  = den18_ff;
      dzero_src[0] = zero18_ff;
      for (int j = 1; j < K; j++) begin
         rem_src[j]   = rem_ff[j-1];
         q_src[j]     = q_ff[j-1];
         ovf_src[j]   = ovf_ff[j-1];
         neg_src[j]   = neg_ff[j-1];
         dden_src[j]  = dden_ff[j-1];
         dzero_src[j] = dzero_ff[j-1];
      end
   end

   always_comb begin
      for (int j = 0; j < K; j++) begin
         dsh[j] = TW'(dden_src[j]) << (K - 1 - j);
         for (int l = 0; l < 3; l++) begin
            ge[j][l]     = (rem_src[j][l] >= dsh[j]);
            rem_in[j][l] = rem_src[j][l];
            q_in[j][l]   = q_src[j][l];
            ovf_in[j][l] = ovf_src[j][l];
            if (j == 0) begin
               ovf_in[j][l] = ge[j][l];
            end else if (ge[j][l]) begin
               rem_in[j][l]         = rem_src[j][l] - dsh[j];
               q_in[j][l][K-1-j]    = 1'b1;
            end
         end
      end
   end

   // sign and saturation
   always_comb begin
      sat_any = 1'b0;
      for (int l = 0; l < 3; l++) begin
         if (!neg_ff[K-1][l]) begin
            if (ovf_ff[K-1][l] || q_ff[K-1][l][COORD_WIDTH-1]) begin
               res[l]  = COORD_MAX;
               sat_any = 1'b1;
            end else begin
               res[l] = q_ff[K-1][l];
            end
         end else begin
            if (ovf_ff[K-1][l] || (q_ff[K-1][l] > NEG_LIMIT)) begin
               res[l]  = COORD_MIN;
               sat_any = 1'b1;
            end else begin
               res[l] = COORD_WIDTH'(-q_ff[K-1][l]);
            end
         end
      end
      if (dzero_ff[K-1]) begin
         rsp_in.center_x_out = '0;
         rsp_in.center_y_out = '0;
         rsp_in.center_z_out = '0;
         rsp_in.status       = STATUS_COLLINEAR;
      end else begin
         rsp_in.center_x_out = res[0];
         rsp_in.center_y_out = res[1];
         rsp_in.center_z_out = res[2];
         rsp_in.status       = sat_any ? STATUS_SATURATED : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff     <= req_word;
         a2_ff     <= a2_in;
         u2_ff     <= u2_in;
         v2_ff     <= v2_in;

         ad1_ff[0] <= a2_ff;
         ud1_ff[0] <= u2_ff;
         vd1_ff[0] <= v2_ff;
         ad2_ff[0] <= a7_ff;
         nd2_ff[0] <= n7_ff;
         dd3_ff[0] <= den12_ff;
         zd3_ff[0] <= zero12_ff;
         for (int s = 1; s < MUL_LAT; s++) begin
            ad1_ff[s] <= ad1_ff[s-1];
            ud1_ff[s] <= ud1_ff[s-1];
            vd1_ff[s] <= vd1_ff[s-1];
            ad2_ff[s] <= ad2_ff[s-1];
            nd2_ff[s] <= nd2_ff[s-1];
            dd3_ff[s] <= dd3_ff[s-1];
            zd3_ff[s] <= zd3_ff[s-1];
         end

         n7_ff     <= n7_in;
         uu7_ff    <= uu7_in;
         vv7_ff    <= vv7_in;
         a7_ff     <= ad1_ff[MUL_LAT-1];
         u7_ff     <= ud1_ff[MUL_LAT-1];
         v7_ff     <= vd1_ff[MUL_LAT-1];

         den12_ff  <= den12_in;
         zero12_ff <= zero12_in;
         w12_ff    <= w12_in;
         n12_ff    <= nd2_ff[MUL_LAT-1];
         a12_ff    <= ad2_ff[MUL_LAT-1];

         t17_ff    <= t17_in;
         den17_ff  <= dd3_ff[MUL_LAT-1];
         zero17_ff <= zd3_ff[MUL_LAT-1];

         mag18_ff  <= mag18_in;
         for (int l = 0; l < 3; l++) begin
            neg18_ff[l] <= t17_ff[l][TW-1];
         end
         den18_ff  <= DENW'(den17_ff);
         zero18_ff <= zero17_ff;

         rem_ff    <= rem_in;
         q_ff      <= q_in;
         ovf_ff    <= ovf_in;
         neg_ff    <= neg_src;
         dden_ff   <= dden_src;
         dzero_ff  <= dzero_src;

         rsp_ff    <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

   a_collinear_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == STATUS_COLLINEAR |->
         rsp_word.center_x_out == '0 && rsp_word.center_y_out == '0 &&
         rsp_word.center_z_out == '0)
      else $error("collinear word carries a nonzero centre");

   a_sat_at_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == STATUS_SATURATED |->
         rsp_word.center_x_out == COORD_MAX || rsp_word.center_x_out == COORD_MIN ||
         rsp_word.center_y_out == COORD_MAX || rsp_word.center_y_out == COORD_MIN ||
         rsp_word.center_z_out == COORD_MAX || rsp_word.center_z_out == COORD_MIN)
      else $error("saturated word has no coordinate at a range limit");

   a_no_accept_when_held : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !(rsp_valid && rsp_stall))
      else $error("word taken while the pipeline is held");

   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

// ----- dv/circumcenter_three_points_3d_core_test.sv -----
// self-checking testbench of the three-point circumcentre core
module circumcenter_three_points_3d_core_test;
   import cc3d_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 44;
   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   rsp_type centre_queue[$];
   int      fail_count = 0;
   int      send_idle = 0;
   int      recv_idle = 0;
   int      cycle_count = 0;

   circumcenter_three_points_3d_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic signed [255:0] quot(input logic signed [255:0] num,
                                                 input logic signed [255:0] den);
      logic signed [255:0] an;
      logic signed [255:0] ad;
      logic signed [255:0] q;
      begin
         an = (num < 0) ? -num : num;
         ad = (den < 0) ? -den : den;
         q = an / ad;
         quot = ((num < 0) != (den < 0)) ? -q : q;
      end
   endfunction

   function automatic rsp_type circumcentre(input req_type r);
      logic signed [255:0] ax, ay, az, ux, uy, uz, vx, vy, vz, nx, ny, nz, nn;
      logic signed [255:0] uu, vv, wx, wy, wz, den;
      logic signed [255:0] t[3];
      logic signed [255:0] q;
      rsp_type res;
      logic sat;
      begin
         ax = 256'(r.first_x); ay = 256'(r.first_y); az = 256'(r.first_z);
         ux = 256'(r.second_x) - ax; uy = 256'(r.second_y) - ay;
         uz = 256'(r.second_z) - az;
         vx = 256'(r.third_x) - ax; vy = 256'(r.third_y) - ay;
         vz = 256'(r.third_z) - az;
         nx = uy * vz - uz * vy;
         ny = uz * vx - ux * vz;
         nz = ux * vy - uy * vx;
         nn = nx * nx + ny * ny + nz * nz;
         res = '0;
         if (nn == 0) begin
            res.status = STATUS_COLLINEAR;
            return res;
         end
         uu = ux * ux + uy * uy + uz * uz;
         vv = vx * vx + vy * vy + vz * vz;
         wx = uu * vx - vv * ux;
         wy = uu * vy - vv * uy;
         wz = uu * vz - vv * uz;
         den = nn + nn;
         t[0] = ax * den + wy * nz - wz * ny;
         t[1] = ay * den + wz * nx - wx * nz;
         t[2] = az * den + wx * ny - wy * nx;
         sat = 1'b0;
         for (int k = 0; k < 3; k++) begin
            q = quot(t[k], den);
            if (q > 256'sd8388607) begin
               q = 256'sd8388607; sat = 1'b1;
            end else if (q < -256'sd8388608) begin
               q = -256'sd8388608; sat = 1'b1;
            end
            if (k == 0) res.center_x_out = q[23:0];
            else if (k == 1) res.center_y_out = q[23:0];
            else res.center_z_out = q[23:0];
         end
         res.status = sat ? STATUS_SATURATED : STATUS_OK;
         return res;
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (centre_queue.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = centre_queue.pop_front();
            if (rsp_word.center_x_out !== want.center_x_out)
               report_mismatch("x", rsp_word.center_x_out, want.center_x_out);
            if (rsp_word.center_y_out !== want.center_y_out)
               report_mismatch("y", rsp_word.center_y_out, want.center_y_out);
            if (rsp_word.center_z_out !== want.center_z_out)
               report_mismatch("z", rsp_word.center_z_out, want.center_z_out);
            if (rsp_word.status !== want.status)
               report_mismatch("status", rsp_word.status, want.status);
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   task automatic send_word(input req_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      centre_queue.push_back(circumcentre(r));
      @(negedge clock);
   endtask

   function automatic logic [23:0] rand_coord(input int mode);
      case (mode)
         0: rand_coord = 24'($urandom);
         1: rand_coord = 24'($urandom_range(2047)) - 24'd1024;
         2: rand_coord = $urandom_range(1) ? 24'h7fffff - 24'($urandom_range(3))
                                           : 24'h800000 + 24'($urandom_range(3));
         default: rand_coord = (24'($urandom_range(255)) - 24'd128) << 16;
      endcase
   endfunction

   task automatic test_directed();
      req_type r;
      r = '0; send_word(r);
      r = '{24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 24'h800000,
            24'h7fffff, 24'h800000, 24'h0};
      send_word(r);
      r = '{24'h800000, 24'h0, 24'h0, 24'h7fffff, 24'h0, 24'h0, 24'h0, 24'h7fffff, 24'h0};
      send_word(r);
      r = '{24'h10000, 24'h0, 24'h0, 24'h0, 24'h10000, 24'h0, 24'h0, 24'h0, 24'h10000};
      send_word(r);
      r = '{24'h0, 24'h0, 24'h0, 24'h10000, 24'h10000, 24'h10000, 24'h20000, 24'h20000,
            24'h20000};
      send_word(r);
      r = '{24'h0, 24'h0, 24'h0, 24'h1, 24'h0, 24'h0, 24'h0, 24'h1, 24'h0};
      send_word(r);
      r = '{24'h0, 24'h0, 24'h0, 24'h100, 24'h0, 24'h0, 24'h101, 24'h1, 24'h0};
      send_word(r);
      r = '{24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
            24'h7fffff, 24'h7fffff, 24'h7fffff};
      send_word(r);
      r = {9{24'hffffff}}; send_word(r);
      r = {9{24'h555555}}; send_word(r);
   endtask

   task automatic test_random(input int count);
      req_type r;
      logic [23:0] c[9];
      int mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(3);
         foreach (c[k]) c[k] = rand_coord(($urandom_range(3) == 0) ? $urandom_range(3) : mode);
         if ($urandom_range(19) == 0) begin
            c[3] = c[0]; c[4] = c[1]; c[5] = c[2];
         end else if ($urandom_range(19) == 0) begin
            c[6] = c[0] + 24'd2 * (c[3] - c[0]); c[7] = c[1] + 24'd2 * (c[4] - c[1]);
            c[8] = c[2] + 24'd2 * (c[5] - c[2]);
         end
         r = '{c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]};
         send_word(r);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (centre_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle = 16; recv_idle = 62;
      test_directed();
      test_random(500);
      drain_results();
      send_idle = 62; recv_idle = 16;
      test_random(500);
      send_idle = 0; recv_idle = 0;
      test_random(540);
      drain_results();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
